// File: rtl/bjsq_pkg.sv
package bjsq_pkg;

  // Longest output sequence of one request: open quote, six-byte escape,
  // close quote and terminator.
  localparam int unsigned SEQ_MAX = 9;
  localparam int unsigned SEQ_LEN_W = 4;
  localparam int unsigned ESC_MAX = 6;
  localparam int unsigned CAP_W = 16;
  localparam int unsigned COUNT_W = 17;

  localparam logic [CAP_W-1:0] CAP_RESET = 16'd4096;
  localparam logic [CAP_W-1:0] CAP_MIN_OPEN = 16'd3;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_NL = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_N = 8'h6e;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_CTRL_END = 8'h20;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef logic [7:0] byte_t;

  // Bytes produced by one request, in order.
  typedef struct packed {
    byte_t [SEQ_MAX-1:0] bytes;
    logic [SEQ_LEN_W-1:0] len;
    logic term;
  } seq_t;

  // Per-string tracking state.
  typedef struct packed {
    logic opened;
    logic [COUNT_W-1:0] written_count;
    logic stopped;
  } str_state_t;

  typedef struct packed {
    byte_t [ESC_MAX-1:0] bytes;
    logic [2:0] len;
  } esc_t;

  function automatic byte_t hex_digit(input logic [3:0] v);
    byte_t d;
    if (v < 4'd10) begin
      d = CH_ZERO + {4'd0, v};
    end else begin
      d = CH_LOW_A + {4'd0, v} - 8'd10;
    end
    return d;
  endfunction

  // JSON escape of one text byte.
  function automatic esc_t escape_of(input byte_t c);
    esc_t e;
    e.bytes = '0;
    e.len = 3'd2;
    e.bytes[0] = CH_BSLASH;
    case (c)
      CH_QUOTE: e.bytes[1] = CH_QUOTE;
      CH_BSLASH: e.bytes[1] = CH_BSLASH;
      CH_NL: e.bytes[1] = CH_N;
      CH_CR: e.bytes[1] = CH_R;
      CH_TAB: e.bytes[1] = CH_T;
      default: begin
        if (c < CH_CTRL_END) begin
          e.bytes[1] = CH_U;
          e.bytes[2] = CH_ZERO;
          e.bytes[3] = CH_ZERO;
          e.bytes[4] = hex_digit(c[7:4]);
          e.bytes[5] = hex_digit(c[3:0]);
          e.len = 3'd6;
        end else begin
          e.bytes[0] = c;
          e.len = 3'd1;
        end
      end
    endcase
    return e;
  endfunction

endpackage

// File: rtl/bjsq_expand.sv
module bjsq_expand (
  input  logic [7:0]                 byte_in,
  input  logic                       byte_valid,
  input  logic                       last,
  input  logic [bjsq_pkg::CAP_W-1:0] capacity,
  input  bjsq_pkg::str_state_t       state,
  output bjsq_pkg::str_state_t       state_next,
  output bjsq_pkg::seq_t             seq
);
  import bjsq_pkg::*;

  esc_t esc;
  logic open_now;
  logic open_ok;
  logic [COUNT_W-1:0] wc0;
  logic [COUNT_W-1:0] wc1;
  logic stop0;
  logic stop1;
  logic fits;
  logic emit_text;
  logic [COUNT_W:0] need;
  logic [SEQ_LEN_W-1:0] pos;

  // Open, escape and close decisions for one request.
  always_comb begin
    esc = escape_of(byte_in);
    open_now = !state.opened;
    open_ok = capacity >= CAP_MIN_OPEN;
    wc0 = open_now ? (open_ok ? COUNT_W'(1) : '0) : state.written_count;
    stop0 = open_now ? !open_ok : state.stopped;
    need = {1'b0, wc0} + (COUNT_W+1)'(esc.len) + (COUNT_W+1)'(2);
    fits = need <= (COUNT_W+1)'(capacity);
    emit_text = byte_valid && !stop0 && (byte_in != CH_NUL) && fits;
    stop1 = stop0 || (byte_valid && ((byte_in == CH_NUL) || !fits));
    wc1 = emit_text ? wc0 + COUNT_W'(esc.len) : wc0;

    state_next.opened = !last;
    state_next.written_count = last ? '0 : wc1;
    state_next.stopped = last ? 1'b0 : stop1;
  end

  // Lay the output bytes out in order.
  always_comb begin
    seq.bytes = '0;
    seq.term = 1'b0;
    pos = '0;
    if (open_now && open_ok) begin
      seq.bytes[0] = CH_QUOTE;
      pos = SEQ_LEN_W'(1);
    end
    if (emit_text) begin
      for (int j = 0; j < ESC_MAX; j++) begin
        if (3'(j) < esc.len) begin
          seq.bytes[pos + SEQ_LEN_W'(j)] = esc.bytes[j];
        end
      end
      pos = pos + SEQ_LEN_W'(esc.len);
    end
    if (last) begin
      if (wc1 != '0) begin
        seq.bytes[pos] = CH_QUOTE;
        seq.bytes[pos + SEQ_LEN_W'(1)] = CH_NUL;
        pos = pos + SEQ_LEN_W'(2);
        seq.term = 1'b1;
      end else if (capacity != '0) begin
        seq.bytes[pos] = CH_NUL;
        pos = pos + SEQ_LEN_W'(1);
        seq.term = 1'b1;
      end
    end
    seq.len = pos;
  end

endmodule

// File: rtl/bjsq_drain.sv
module bjsq_drain (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  bjsq_pkg::seq_t       seq_in,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 run_last,
  output logic                 string_end
);
  import bjsq_pkg::*;

  byte_t [SEQ_MAX-1:0] buf_bytes;
  logic [SEQ_LEN_W-1:0] buf_len;
  logic [SEQ_LEN_W-1:0] buf_pos;
  logic buf_term;
  logic out_free;
  logic have;
  logic move;
  logic final_byte;

  assign out_free = !out_valid || !out_stall;
  assign have = buf_pos != buf_len;
  assign move = have && out_free;
  assign final_byte = (buf_pos + SEQ_LEN_W'(1)) == buf_len;
  // A new request may enter once the buffered sequence is gone by the edge.
  assign ready = !have || (move && final_byte);

  // Sequence buffer and read pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_len <= '0;
      buf_pos <= '0;
    end else if (load) begin
      buf_len <= seq_in.len;
      buf_pos <= '0;
    end else if (move) begin
      buf_pos <= buf_pos + SEQ_LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_bytes <= seq_in.bytes;
      buf_term <= seq_in.term;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_byte <= buf_bytes[buf_pos];
      run_last <= final_byte;
      string_end <= final_byte && buf_term;
    end
  end

  // The read pointer never runs past the sequence.
  assert property (@(posedge clk) disable iff (rst) buf_pos <= buf_len)
    else $error("read pointer past sequence length");

  // A terminator always closes the request's results.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && string_end |-> run_last && (out_byte == CH_NUL))
    else $error("terminator not final or not zero");

  // A load only happens when the buffer is drained or draining.
  assert property (@(posedge clk) disable iff (rst)
    load |-> !have || (move && final_byte))
    else $error("sequence overwritten before drained");

  // A taken byte moves the pointer forward by one.
  assert property (@(posedge clk) disable iff (rst)
    move && !load |=> buf_pos == $past(buf_pos) + SEQ_LEN_W'(1))
    else $error("read pointer did not advance");

endmodule

// File: rtl/bounded_json_string_quote.sv
// Quotes and escapes a text, one byte per request, as a JSON string bounded by
// the capacity register. Each request produces zero to nine output bytes:
// the opening quote on a string's first request, the byte or its escape, and
// the closing quote plus zero terminator on the request marked last. A
// request is expanded combinationally into a small sequence buffer that feeds
// a registered output. Plain bytes stream at one per cycle while the output is
// not stalled. The input stalls while the buffer drains, one byte per cycle
// when the output is not stalled; the next request is taken as the last
// buffered byte moves to the output. Capacity may only be written while the
// block is idle.
module bounded_json_string_quote (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_in,
  input  logic        byte_valid,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        string_end
);
  import bjsq_pkg::*;

  logic [CAP_W-1:0] capacity;
  str_state_t state;
  str_state_t state_next;
  seq_t seq;
  logic ready;
  logic accept;

  assign in_stall = !ready;
  assign accept = in_valid && ready;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_write) begin
      capacity <= cfg_data;
    end
  end

  // String state advances with every accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  bjsq_expand u_expand (
    .byte_in    (byte_in),
    .byte_valid (byte_valid),
    .last       (last),
    .capacity   (capacity),
    .state      (state),
    .state_next (state_next),
    .seq        (seq)
  );

  bjsq_drain u_drain (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .seq_in     (seq),
    .ready      (ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .string_end (string_end)
  );

endmodule

// File: tb/tb.sv
module tb;
  import bjsq_pkg::*;

  localparam int LONG_HOLD = 300;
  localparam int DRAIN_SLACK = 12;

  // One output byte as the checker sees it.
  typedef struct packed {
    logic [7:0] data;
    logic       tail;
    logic       term;
  } quote_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  byte_in = '0;
  logic        byte_valid = 1'b0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        run_last;
  logic        string_end;

  // Predictor state: capacity register and the per-string tracking.
  logic [15:0] cap_reg = CAP_RESET;
  logic        str_open = 1'b0;
  logic [16:0] str_count = '0;
  logic        str_halted = 1'b0;

  quote_out_t  expected_bytes[$];
  int          failures = 0;
  int          requests_sent = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_req = 1'b0;
  int          held_cycles = 0;

  bounded_json_string_quote u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_in    (byte_in),
    .byte_valid (byte_valid),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .string_end (string_end)
  );

  always #5 clk = ~clk;

  // Works out the bytes one accepted request produces and queues them.
  function automatic void predict_request(input logic [7:0] b, input logic bv,
                                          input logic lst);
    logic [7:0] esc [0:5];
    int n;
    quote_out_t run[$];
    n = 0;
    if (!str_open) begin
      str_open = 1'b1;
      if (cap_reg >= CAP_MIN_OPEN) begin
        run.push_back('{CH_QUOTE, 1'b0, 1'b0});
        str_count = 17'd1;
        str_halted = 1'b0;
      end else begin
        str_count = '0;
        str_halted = 1'b1;
      end
    end
    if (bv && !str_halted) begin
      if (b == CH_NUL) begin
        str_halted = 1'b1;
      end else begin
        esc[0] = CH_BSLASH;
        n = 2;
        case (b)
          CH_QUOTE: esc[1] = CH_QUOTE;
          CH_BSLASH: esc[1] = CH_BSLASH;
          CH_NL: esc[1] = CH_N;
          CH_CR: esc[1] = CH_R;
          CH_TAB: esc[1] = CH_T;
          default: begin
            if (b < CH_CTRL_END) begin
              esc[1] = CH_U;
              esc[2] = CH_ZERO;
              esc[3] = CH_ZERO;
              esc[4] = CH_ZERO + {4'd0, b[7:4]};
              esc[5] = (b[3:0] < 4'd10) ? CH_ZERO + {4'd0, b[3:0]}
                                        : CH_LOW_A + {4'd0, b[3:0]} - 8'd10;
              n = 6;
            end else begin
              esc[0] = b;
              n = 1;
            end
          end
        endcase
        // The escape must leave room for the closing quote and terminator.
        if (int'(str_count) + n + 2 > int'(cap_reg)) begin
          str_halted = 1'b1;
        end else begin
          for (int i = 0; i < n; i++) begin
            run.push_back('{esc[i], 1'b0, 1'b0});
          end
          str_count = str_count + 17'(n);
        end
      end
    end
    if (lst) begin
      if (str_count != 0) begin
        run.push_back('{CH_QUOTE, 1'b0, 1'b0});
        run.push_back('{CH_NUL, 1'b0, 1'b1});
      end else if (cap_reg != 0) begin
        run.push_back('{CH_NUL, 1'b0, 1'b1});
      end
      str_open = 1'b0;
      str_count = '0;
      str_halted = 1'b0;
    end
    if (run.size() != 0) begin
      run[run.size()-1].tail = 1'b1;
    end
    foreach (run[i]) begin
      expected_bytes.push_back(run[i]);
    end
  endfunction

  // Offers one request, with an occasional gap before it, and waits for it.
  task automatic send_request(input logic [7:0] b, input logic bv, input logic lst);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    byte_in = b;
    byte_valid = bv;
    last = lst;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(b, bv, lst);
    requests_sent++;
    @(negedge clk);
  endtask

  // Holds off new requests until every expected byte has come out.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    wait_drained();
    cfg_data = value;
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
    cap_reg = value;
  endtask

  // Receiver side: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_req) begin
      out_stall = 1'b1;
      held_cycles++;
      if (held_cycles >= LONG_HOLD) begin
        hold_req = 1'b0;
        held_cycles = 0;
      end
    end else begin
      out_stall = (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compares every accepted output byte with the oldest expectation.
  always @(posedge clk) begin : check_results
    quote_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("unexpected output: byte %02h run_last %0d string_end %0d",
                   out_byte, run_last, string_end);
        end
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.data || run_last !== want.tail ||
            string_end !== want.term) begin
          failures++;
          if (failures <= 10) begin
            $display({"mismatch: expected byte %02h run_last %0d string_end %0d, ",
                      "got byte %02h run_last %0d string_end %0d"},
                     want.data, want.tail, want.term, out_byte, run_last,
                     string_end);
          end
        end
      end
    end
  end

  // Text bytes weighted toward printable text, with escapes and stray values.
  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 8'($urandom_range(8'h20, 8'h7e));
    if (r < 70) begin
      case ($urandom_range(4))
        0: return CH_QUOTE;
        1: return CH_BSLASH;
        2: return CH_NL;
        3: return CH_CR;
        default: return CH_TAB;
      endcase
    end
    if (r < 82) return 8'($urandom_range(8'h01, 8'h1f));
    if (r < 96) return 8'($urandom_range(8'h7f, 8'hff));
    return CH_NUL;
  endfunction

  // Mostly small capacities so that overflow is common, plus the extremes.
  function automatic logic [15:0] pick_capacity();
    int r;
    r = $urandom_range(99);
    if (r < 6) return 16'($urandom_range(0, 2));
    if (r < 14) return 16'hffff;
    if (r < 24) return CAP_RESET;
    return 16'($urandom_range(3, 48));
  endfunction

  task automatic send_random_string();
    int len;
    len = $urandom_range(0, 12);
    for (int i = 0; i < len; i++) begin
      send_request(pick_text_byte(), $urandom_range(99) >= 6, 1'b0);
    end
    // Close with either an empty request or one more text byte.
    if ($urandom_range(1)) begin
      send_request(8'($urandom_range(255)), 1'b0, 1'b1);
    end else begin
      send_request(pick_text_byte(), 1'b1, 1'b1);
    end
  endtask

  task automatic run_random_phase(input int s_pct, input int r_pct, input int count);
    int stop_at;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      write_capacity(pick_capacity());
      repeat (3) send_random_string();
    end
  endtask

  // Every escape class and the byte extremes, at the reset capacity.
  task automatic test_escapes();
    logic [7:0] text [0:10];
    text = '{8'h20, 8'h7f, 8'hff, CH_QUOTE, CH_BSLASH, CH_NL, CH_CR, CH_TAB,
             8'h01, 8'h1a, 8'h1f};
    foreach (text[i]) send_request(text[i], 1'b1, 1'b0);
    send_request(8'h80, 1'b1, 1'b1);
  endtask

  // A zero byte ends the text; later bytes are dropped.
  task automatic test_zero_stop();
    send_request(8'h61, 1'b1, 1'b0);
    send_request(CH_NUL, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'hff, 1'b0, 1'b1);
  endtask

  // A byte that does not fit stops the string, for plain and escaped bytes.
  task automatic test_overflow();
    write_capacity(16'd5);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b0);
    send_request(8'h64, 1'b1, 1'b1);
    write_capacity(16'd6);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h01, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b1);
  endtask

  // Capacities below three give only a terminator, or nothing at zero.
  task automatic test_small_capacity();
    for (int c = 0; c < 3; c++) begin
      write_capacity(16'(c));
      send_request(8'h7a, 1'b1, 1'b1);
    end
    write_capacity(CAP_MIN_OPEN);
    send_request(8'h7a, 1'b0, 1'b1);
  endtask

  // Shrinking the capacity inside a string still closes it properly.
  task automatic test_capacity_shrink();
    write_capacity(16'hffff);
    send_request(8'h61, 1'b1, 1'b0);
    write_capacity(16'd0);
    send_request(8'h62, 1'b1, 1'b1);
  endtask

  // Long receiver hold-off while the sender keeps offering requests.
  task automatic test_backpressure();
    write_capacity(CAP_RESET);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_request(8'($urandom_range(8'h20, 8'h7e)), 1'b1, i == 39);
    end
    wait_drained();
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst = 1'b0;
    send_idle_pct = 10;
    recv_idle_pct = 30;
    test_escapes();
    test_zero_stop();
    test_overflow();
    test_small_capacity();
    test_capacity_shrink();
    test_backpressure();
    run_random_phase(13, 74, 75);
    run_random_phase(74, 13, 75);
    run_random_phase(0, 0, 75);
    wait_drained();
    if (failures == 0 && expected_bytes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Overall time limit in case the block hangs.
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: filelist.f
rtl/bjsq_pkg.sv
rtl/bjsq_expand.sv
rtl/bjsq_drain.sv
rtl/bounded_json_string_quote.sv
tb/tb.sv
